// ----- rtl/cloop_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cloop_pkg: shared types and constants of the current loop step
// Sequencer states, unit status, register indexes, fixed-point constants
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cloop_pkg;

    localparam int CL_DATA_WIDTH      = 16;
    localparam int CL_SINE_INDEX_BITS = 10;

    localparam int CFG_INDEX_W = 4;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 152;

    localparam int MUL_A_W  = 38;
    localparam int MUL_B_W  = 18;
    localparam int MUL_P_W  = 56;
    localparam int ACC_W    = 58;
    localparam int TIME_W   = 40;
    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 40;

    localparam int CORDIC_ITERS = 16;
    localparam int CORDIC_W     = 34;

    // Q16 scaled constants
    localparam logic signed [MUL_B_W-1:0] K_INV_SQRT3 = 18'sd37837;   // 1/sqrt3
    localparam logic signed [MUL_B_W-1:0] K_SQRT3     = 18'sd113512;  // sqrt3
    localparam logic signed [MUL_B_W-1:0] K_ONE_HALF  = 18'sd98304;   // 1.5
    localparam logic signed [MUL_B_W-1:0] K_HALF_SQ3  = 18'sd56756;   // sqrt3/2
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0  = 34'sd652032874;

    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;
    localparam logic [2:0] SECTOR_NONE = 3'd0;
    localparam logic [2:0] SECTOR_ALL  = 3'd7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KP_D       = 4'd0,
        REG_KI_D       = 4'd1,
        REG_KP_Q       = 4'd2,
        REG_KI_Q       = 4'd3,
        REG_KB_GAIN    = 4'd4,
        REG_VOLT_MAX   = 4'd5,
        REG_VOLT_MIN   = 4'd6,
        REG_PWM_PERIOD = 4'd7
    } cfg_reg_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_TRIG, ST_IBE, ST_IDA, ST_IDB, ST_IQA, ST_IQB, ST_ERR,
        ST_PI1, ST_PI2, ST_PI3, ST_PI4, ST_PI5,
        ST_UA1, ST_UA2, ST_UB1, ST_UB2, ST_SEC1, ST_SEC2,
        ST_N1, ST_N2A, ST_N2B, ST_N2C, ST_N2D, ST_N3,
        ST_DIV, ST_DWAIT, ST_SEL, ST_OVX, ST_OVY, ST_TA, ST_TBC, ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        DT_T1, DT_T2, DT_T3, DT_TX, DT_TY
    } div_tag_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    function automatic logic signed [31:0] atan_lut(input logic [3:0] i);
        logic signed [31:0] r;
        case (i)
            4'd0:    r = 32'sd536870912;
            4'd1:    r = 32'sd316933406;
            4'd2:    r = 32'sd167458908;
            4'd3:    r = 32'sd85004756;
            4'd4:    r = 32'sd42667331;
            4'd5:    r = 32'sd21354465;
            4'd6:    r = 32'sd10679838;
            4'd7:    r = 32'sd5340245;
            4'd8:    r = 32'sd2670163;
            4'd9:    r = 32'sd1335087;
            4'd10:   r = 32'sd667544;
            4'd11:   r = 32'sd333772;
            4'd12:   r = 32'sd166886;
            4'd13:   r = 32'sd83443;
            4'd14:   r = 32'sd41722;
            default: r = 32'sd20861;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/foc_current_loop_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_current_loop_step: one current-loop update per PWM period
// Clarke/Park transform, d/q PI regulators, inverse Park and SVPWM compares.
// ----------------------------------------------------------------------------
// Usage:
//   Send one word per PWM period on the s_ channel (phase currents, rotor
//   angle, d/q references, bus voltage). The block drops s_tready while it
//   works and raises it again once the result sits in the output register.
//   One result word comes out on the m_ channel per input word.
//   Each word takes a CORDIC pass, a run of sequencer steps on the shared
//   38x18 multiplier, and three divisions on the shared divider (two more
//   when the active times overmodulate).
//   With zero bus voltage the three divisions are skipped.
//   If the receiver stalls, the result holds in the output register; the
//   block takes the next word meanwhile and waits only when that next
//   result is ready before the old one is taken.
//   Reset clears both integrators, restores default gains, limits and
//   period, and empties the output register.
//   Write registers on the cfg_ channel only while the block is idle.
// ----------------------------------------------------------------------------
module foc_current_loop_step
    import cloop_pkg::*;
#(
    parameter int DATA_WIDTH      = CL_DATA_WIDTH,
    parameter int SINE_INDEX_BITS = CL_SINE_INDEX_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // ia[15:0], ib[31:16], rotor_angle[47:32], id_ref[63:48],
    // iq_ref[79:64], udc[94:80], zero pad[95]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cmp1[14:0], cmp2[29:15], cmp3[44:30], sector_code[47:45],
    // overmodulated[48], i_alpha[64:49], i_beta[80:65], u_alpha[96:81],
    // u_beta[112:97], id_meas[128:113], iq_meas[144:129], zero pad[151:145]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    // width that holds any value saturated to DATA_WIDTH bits
    localparam int VW = 25;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        kp_d_reg, ki_d_reg, kp_q_reg, ki_q_reg, kb_reg, period_reg;
    logic signed [15:0] vmax_reg, vmin_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_d_reg   <= 16'd256;
            ki_d_reg   <= 16'd16;
            kp_q_reg   <= 16'd256;
            ki_q_reg   <= 16'd16;
            kb_reg     <= 16'd256;
            vmax_reg   <= 16'sh7FFF;
            vmin_reg   <= 16'sh8000;
            period_reg <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KP_D:       kp_d_reg   <= cfg_data;
                REG_KI_D:       ki_d_reg   <= cfg_data;
                REG_KP_Q:       kp_q_reg   <= cfg_data;
                REG_KI_Q:       ki_q_reg   <= cfg_data;
                REG_KB_GAIN:    kb_reg     <= cfg_data;
                REG_VOLT_MAX:   vmax_reg   <= cfg_data;
                REG_VOLT_MIN:   vmin_reg   <= cfg_data;
                REG_PWM_PERIOD: period_reg <= cfg_data;
                default:        ;   // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                    input int s);
        return (v + (58'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [VW-1:0] satd(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        hi = (58'sd1 <<< (DATA_WIDTH - 1)) - 58'sd1;
        if (v > hi)
            return hi[VW-1:0];
        else if (v < ~hi)
            return VW'(~hi);
        else
            return v[VW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // control and datapath registers
    // ------------------------------------------------------------------
    state_t   state_reg, state_next;
    div_tag_t tag_reg, tag_next;
    logic     axis_reg, axis_next;     // 0: d axis, 1: q axis
    logic     m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic signed [15:0]       ia_reg, ib_reg, idr_reg, iqr_reg;
    logic [15:0]              angle_reg;
    logic [14:0]              udc_reg;
    logic signed [VW-1:0]     ial_reg, ibe_reg, idm_reg, iqm_reg, ua_reg, ub_reg;
    logic signed [15:0]       ud_reg, uq_reg;
    logic signed [VW:0]       err_reg;
    logic signed [ACC_W-1:0]  t_reg, acc_reg, acc2_reg;
    logic signed [16:0]       v_reg;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [31:0]       integ_d_reg, integ_q_reg;
    logic signed [TIME_W-1:0] t1_reg, t2_reg, t3_reg, tx_reg, ty_reg, sum_reg;
    logic signed [TIME_W-1:0] ta_reg, tb_reg, tc_reg;
    logic [2:0]               n_reg;
    logic                     ovm_reg, neg_reg;

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    unit_sts_t          cordic_sts, div_sts;
    logic signed [15:0] cos_v, sin_v;
    logic               div_start, div_skip;
    logic [DIV_NUM_W-1:0] div_dividend, div_q, num_mag;
    logic [DIV_DEN_W-1:0] div_den;

    cloop_cordic #(
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s_accept),
        .angle (s_tdata[47:32]),
        .sts   (cordic_sts),
        .cos_q (cos_v),
        .sin_q (sin_v)
    );

    cloop_div #(
        .NW (DIV_NUM_W),
        .DW (DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_den),
        .sts      (div_sts),
        .quotient (div_q)
    );

    // numerator magnitude plus half the divisor gives round-half-away
    always_comb
    begin
        num_mag = prod_reg[MUL_P_W-1] ? DIV_NUM_W'(-prod_reg) : DIV_NUM_W'(prod_reg);
        if (tag_reg == DT_TX || tag_reg == DT_TY)
            div_den = sum_reg[DIV_DEN_W-1:0];
        else
            div_den = DIV_DEN_W'({udc_reg, 16'd0});
        div_dividend = num_mag + DIV_NUM_W'(div_den >> 1);
        div_skip  = (udc_reg == '0) && (tag_reg == DT_T1 || tag_reg == DT_T2
                                        || tag_reg == DT_T3);
        div_start = (state_reg == ST_DIV) && !div_skip;
    end

    logic signed [TIME_W-1:0] div_val;
    assign div_val = div_skip ? '0
                   : (neg_reg ? -TIME_W'(div_q) : TIME_W'(div_q));

    // ------------------------------------------------------------------
    // shared multiplier operand select
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MUL_B_W-1:0] ts_b, kp_b, ki_b, kb_b, cos_b, sin_b;
    logic signed [ACC_W-1:0]   bc_diff;

    assign ts_b    = MUL_B_W'({2'b00, period_reg});
    assign kp_b    = MUL_B_W'({2'b00, axis_reg ? kp_q_reg : kp_d_reg});
    assign ki_b    = MUL_B_W'({2'b00, axis_reg ? ki_q_reg : ki_d_reg});
    assign kb_b    = MUL_B_W'({2'b00, kb_reg});
    assign cos_b   = MUL_B_W'(cos_v);
    assign sin_b   = MUL_B_W'(sin_v);
    assign bc_diff = (ACC_W'(v_reg) <<< 8) - t_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IBE:
            begin
                mul_a = MUL_A_W'(ia_reg) + (MUL_A_W'(ib_reg) <<< 1);
                mul_b = K_INV_SQRT3;
            end
            ST_IDA:  begin mul_a = MUL_A_W'(ial_reg); mul_b = cos_b; end
            ST_IDB:  begin mul_a = MUL_A_W'(ibe_reg); mul_b = sin_b; end
            ST_IQA:  begin mul_a = MUL_A_W'(ibe_reg); mul_b = cos_b; end
            ST_IQB:  begin mul_a = MUL_A_W'(ial_reg); mul_b = sin_b; end
            ST_PI1:  begin mul_a = MUL_A_W'(err_reg); mul_b = kp_b; end
            ST_PI2:  begin mul_a = MUL_A_W'(err_reg); mul_b = ki_b; end
            ST_PI4:  begin mul_a = bc_diff[MUL_A_W-1:0]; mul_b = kb_b; end
            ST_UA1:  begin mul_a = MUL_A_W'(ud_reg); mul_b = cos_b; end
            ST_UA2:  begin mul_a = MUL_A_W'(uq_reg); mul_b = sin_b; end
            ST_UB1:  begin mul_a = MUL_A_W'(ud_reg); mul_b = sin_b; end
            ST_UB2:  begin mul_a = MUL_A_W'(uq_reg); mul_b = cos_b; end
            ST_SEC1: begin mul_a = MUL_A_W'(ua_reg); mul_b = K_SQRT3; end
            ST_SEC2: begin mul_a = MUL_A_W'(ub_reg); mul_b = K_SQRT3; end
            ST_N1:   begin mul_a = prod_reg[MUL_A_W-1:0]; mul_b = ts_b; end
            ST_N2A:  begin mul_a = MUL_A_W'(ua_reg); mul_b = K_ONE_HALF; end
            ST_N2B:  begin mul_a = MUL_A_W'(ub_reg); mul_b = K_HALF_SQ3; end
            ST_N2D:  begin mul_a = acc_reg[MUL_A_W-1:0]; mul_b = ts_b; end
            ST_N3:   begin mul_a = acc2_reg[MUL_A_W-1:0]; mul_b = ts_b; end
            ST_OVX:  begin mul_a = tx_reg[MUL_A_W-1:0]; mul_b = ts_b; end
            ST_OVY:  begin mul_a = ty_reg[MUL_A_W-1:0]; mul_b = ts_b; end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // combinational pieces used by the datapath
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]  prod_x, tv, pi_sum, sec_a, sec_b;
    logic signed [16:0]       v_clamped;
    logic signed [31:0]       integ_sel, integ_new;
    logic [2:0]               n_raw, n_fix;
    logic signed [TIME_W-1:0] tx_sel, ty_sel, ta_calc, tb_calc, tc_calc;
    logic signed [TIME_W:0]   txy_sum;

    assign prod_x    = ACC_W'(prod_reg);
    assign integ_sel = axis_reg ? integ_q_reg : integ_d_reg;
    assign tv        = rnd(t_reg, 8);

    always_comb
    begin
        if (tv > ACC_W'(vmax_reg))
            v_clamped = 17'(vmax_reg);
        else if (tv < ACC_W'(vmin_reg))
            v_clamped = 17'(vmin_reg);
        else
            v_clamped = tv[16:0];
    end

    // integrator update with back-calculation, saturated to 32 bits
    always_comb
    begin
        pi_sum = ACC_W'(integ_sel) + (prod_x >>> 8) + acc_reg;
        if (pi_sum > 58'sd2147483647)
            integ_new = 32'sh7FFFFFFF;
        else if (pi_sum < -58'sd2147483648)
            integ_new = 32'sh80000000;
        else
            integ_new = pi_sum[31:0];
    end

    // sector from three sign tests; the zero vector folds into sector 6
    always_comb
    begin
        sec_a = prod_x;
        sec_b = ACC_W'(ub_reg) <<< 16;
        n_raw = {(-sec_a - sec_b) > 0, (sec_a - sec_b) > 0, ub_reg > 0};
        n_fix = (n_raw == SECTOR_NONE || n_raw == SECTOR_ALL) ? SECTOR_6 : n_raw;
    end

    always_comb
    begin
        case (n_reg)
            SECTOR_1: begin tx_sel = t3_reg;  ty_sel = t2_reg;  end
            SECTOR_2: begin tx_sel = t2_reg;  ty_sel = -t1_reg; end
            SECTOR_3: begin tx_sel = -t3_reg; ty_sel = t1_reg;  end
            SECTOR_4: begin tx_sel = -t1_reg; ty_sel = t3_reg;  end
            SECTOR_5: begin tx_sel = t1_reg;  ty_sel = -t2_reg; end
            default:  begin tx_sel = -t2_reg; ty_sel = -t3_reg; end
        endcase
        txy_sum = (TIME_W + 1)'(tx_sel) + (TIME_W + 1)'(ty_sel);
    end

    always_comb
    begin
        ta_calc = TIME_W'((TIME_W'({24'd0, period_reg}) - tx_reg - ty_reg
                           + TIME_W'(2)) >>> 2);
        tb_calc = ta_reg + ((tx_reg + TIME_W'(1)) >>> 1);
        tc_calc = tb_calc + ((ty_reg + TIME_W'(1)) >>> 1);
    end

    // compare values: map per sector, clamp to 0..Ts/2
    function automatic logic [14:0] clamp_cmp(input logic signed [TIME_W-1:0] k,
                                              input logic [15:0] ts);
        logic [14:0] half;
        half = ts[15:1];
        if (k > TIME_W'({25'd0, half}))
            return half;
        else if (k < 0)
            return 15'd0;
        else
            return k[14:0];
    endfunction

    logic signed [TIME_W-1:0] k1, k2, k3;
    logic [OUT_TDATA_W-1:0]   result_word;

    always_comb
    begin
        case (n_reg)
            SECTOR_1: begin k1 = tb_reg; k2 = ta_reg; k3 = tc_reg; end
            SECTOR_2: begin k1 = ta_reg; k2 = tc_reg; k3 = tb_reg; end
            SECTOR_3: begin k1 = ta_reg; k2 = tb_reg; k3 = tc_reg; end
            SECTOR_4: begin k1 = tc_reg; k2 = tb_reg; k3 = ta_reg; end
            SECTOR_5: begin k1 = tc_reg; k2 = ta_reg; k3 = tb_reg; end
            default:  begin k1 = tb_reg; k2 = tc_reg; k3 = ta_reg; end
        endcase
        result_word = {7'd0, iqm_reg[15:0], idm_reg[15:0], ub_reg[15:0], ua_reg[15:0],
                       ibe_reg[15:0], ial_reg[15:0], ovm_reg, n_reg,
                       clamp_cmp(k3, period_reg), clamp_cmp(k2, period_reg),
                       clamp_cmp(k1, period_reg)};
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        tag_next      = tag_reg;
        axis_next     = axis_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_TRIG;
            ST_TRIG: if (cordic_sts.done) state_next = ST_IBE;
            ST_IBE:  state_next = ST_IDA;
            ST_IDA:  state_next = ST_IDB;
            ST_IDB:  state_next = ST_IQA;
            ST_IQA:  state_next = ST_IQB;
            ST_IQB:  state_next = ST_ERR;
            ST_ERR:
            begin
                axis_next  = 1'b0;
                state_next = ST_PI1;
            end
            ST_PI1:  state_next = ST_PI2;
            ST_PI2:  state_next = ST_PI3;
            ST_PI3:  state_next = ST_PI4;
            ST_PI4:  state_next = ST_PI5;
            ST_PI5:
            begin
                axis_next  = 1'b1;
                state_next = axis_reg ? ST_UA1 : ST_PI1;
            end
            ST_UA1:  state_next = ST_UA2;
            ST_UA2:  state_next = ST_UB1;
            ST_UB1:  state_next = ST_UB2;
            ST_UB2:  state_next = ST_SEC1;
            ST_SEC1: state_next = ST_SEC2;
            ST_SEC2: state_next = ST_N1;
            ST_N1:
            begin
                tag_next   = DT_T1;
                state_next = ST_DIV;
            end
            ST_N2A:  state_next = ST_N2B;
            ST_N2B:  state_next = ST_N2C;
            ST_N2C:  state_next = ST_N2D;
            ST_N2D:
            begin
                tag_next   = DT_T2;
                state_next = ST_DIV;
            end
            ST_N3:
            begin
                tag_next   = DT_T3;
                state_next = ST_DIV;
            end
            ST_DIV:  state_next = ST_DWAIT;
            ST_DWAIT:
            begin
                if (div_skip || div_sts.done)
                begin
                    case (tag_reg)
                        DT_T1:   state_next = ST_N2A;
                        DT_T2:   state_next = ST_N3;
                        DT_T3:   state_next = ST_SEL;
                        DT_TX:   state_next = ST_OVY;
                        default: state_next = ST_TA;
                    endcase
                end
            end
            ST_SEL:  state_next = (txy_sum > (TIME_W + 1)'({25'd0, period_reg}))
                                  ? ST_OVX : ST_TA;
            ST_OVX:
            begin
                tag_next   = DT_TX;
                state_next = ST_DIV;
            end
            ST_OVY:
            begin
                tag_next   = DT_TY;
                state_next = ST_DIV;
            end
            ST_TA:   state_next = ST_TBC;
            ST_TBC:  state_next = ST_OUT;
            ST_OUT:
            begin
                // hold the finished word until the output register frees up
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tag_reg      <= DT_T1;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            integ_d_reg  <= '0;
            integ_q_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            tag_reg      <= tag_next;
            axis_reg     <= axis_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == ST_PI5)
            begin
                if (axis_reg)
                    integ_q_reg <= integ_new;
                else
                    integ_d_reg <= integ_new;
            end
        end
    end

    // payload datapath, advanced by the sequencer state
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (s_accept)
        begin
            ia_reg    <= s_tdata[15:0];
            ib_reg    <= s_tdata[31:16];
            angle_reg <= s_tdata[47:32];
            idr_reg   <= s_tdata[63:48];
            iqr_reg   <= s_tdata[79:64];
            udc_reg   <= s_tdata[94:80];
            ovm_reg   <= 1'b0;
        end
        case (state_reg)
            ST_IBE:  ial_reg <= satd(ACC_W'(ia_reg));
            ST_IDA:  ibe_reg <= satd(rnd(prod_x, 16));
            ST_IDB:  acc_reg <= prod_x;
            ST_IQA:  idm_reg <= satd(rnd(acc_reg + prod_x, 15));
            ST_IQB:  acc_reg <= prod_x;
            ST_ERR:
            begin
                iqm_reg <= satd(rnd(acc_reg - prod_x, 15));
                err_reg <= (VW + 1)'(idr_reg) - (VW + 1)'(idm_reg);
            end
            ST_PI2:  t_reg <= prod_x + ACC_W'(integ_sel);
            ST_PI3:
            begin
                acc_reg <= prod_x;
                v_reg   <= v_clamped;
            end
            ST_PI5:
            begin
                if (axis_reg)
                    uq_reg <= 16'(satd(ACC_W'(v_reg)));
                else
                begin
                    ud_reg  <= 16'(satd(ACC_W'(v_reg)));
                    err_reg <= (VW + 1)'(iqr_reg) - (VW + 1)'(iqm_reg);
                end
            end
            ST_UA2:  acc_reg <= prod_x;
            ST_UB1:  ua_reg  <= satd(rnd(acc_reg - prod_x, 15));
            ST_UB2:  acc_reg <= prod_x;
            ST_SEC1: ub_reg  <= satd(rnd(acc_reg + prod_x, 15));
            ST_SEC2: n_reg   <= n_fix;
            ST_N2B:  acc_reg <= prod_x;
            ST_N2C:
            begin
                acc_reg  <= acc_reg + prod_x;
                acc2_reg <= prod_x - acc_reg;
            end
            ST_DIV:  neg_reg <= prod_reg[MUL_P_W-1];
            ST_DWAIT:
            begin
                if (div_skip || div_sts.done)
                begin
                    case (tag_reg)
                        DT_T1:   t1_reg <= div_val;
                        DT_T2:   t2_reg <= div_val;
                        DT_T3:   t3_reg <= div_val;
                        DT_TX:   tx_reg <= div_val;
                        default: ty_reg <= div_val;
                    endcase
                end
            end
            ST_SEL:
            begin
                tx_reg  <= tx_sel;
                ty_reg  <= ty_sel;
                sum_reg <= txy_sum[TIME_W-1:0];
                if (txy_sum > (TIME_W + 1)'({25'd0, period_reg}))
                    ovm_reg <= 1'b1;
            end
            ST_TA:   ta_reg <= ta_calc;
            ST_TBC:
            begin
                tb_reg <= tb_calc;
                tc_reg <= tc_calc;
            end
            ST_OUT:  if (out_free) m_tdata_reg <= result_word;
            default: ;
        endcase
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_sts.busy && !cordic_sts.busy)
        else $error("input taken while a shared unit is busy");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47:45] != SECTOR_NONE && m_tdata[47:45] != SECTOR_ALL)
        else $error("sector code out of range");

    a_cmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[14:0] <= period_reg[15:1]
                  && m_tdata[29:15] <= period_reg[15:1]
                  && m_tdata[44:30] <= period_reg[15:1])
        else $error("compare value beyond half period");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result word raised outside the output step");

endmodule

// ----- rtl/cloop_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cloop_cordic: iterative sine/cosine unit
// One rotation step per cycle, then quadrant fold and rounding to Q1.15.
// ----------------------------------------------------------------------------
module cloop_cordic
    import cloop_pkg::*;
#(
    parameter int SINE_INDEX_BITS = CL_SINE_INDEX_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        angle,
    output unit_sts_t          sts,
    output logic signed [15:0] cos_q,
    output logic signed [15:0] sin_q
);

    localparam int IW = $clog2(CORDIC_ITERS);

    logic                       busy_reg, fin_reg, done_reg;
    logic [IW-1:0]              iter_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [31:0]         z_reg;
    logic [1:0]                 quad_reg;
    logic signed [15:0]         cos_reg, sin_reg;

    logic [31:0]                phi;
    logic signed [CORDIC_W-1:0] dx, dy, cx, cy;
    logic signed [15:0]         cos_next, sin_next;

    function automatic logic signed [15:0] round_sat(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)
            return 16'sh7FFF;
        else if (r < -34'sd32768)
            return 16'sh8000;
        else
            return r[15:0];
    endfunction

    assign phi = {angle[15 -: SINE_INDEX_BITS], {(32 - SINE_INDEX_BITS){1'b0}}};
    assign dx  = y_reg >>> iter_reg;
    assign dy  = x_reg >>> iter_reg;

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cx = x_reg;
                cy = y_reg;
            end
            2'd1:
            begin
                cx = -y_reg;
                cy = x_reg;
            end
            2'd2:
            begin
                cx = -x_reg;
                cy = -y_reg;
            end
            default:
            begin
                cx = y_reg;
                cy = -x_reg;
            end
        endcase
        cos_next = round_sat(cx);
        sin_next = round_sat(cy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == IW'(CORDIC_ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= {2'b00, phi[29:0]};
            quad_reg <= phi[31:30];
        end
        else if (busy_reg)
        begin
            if (!z_reg[31])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_lut(iter_reg);
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_lut(iter_reg);
            end
        end
        if (fin_reg)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign sts.busy = busy_reg | fin_reg;
    assign sts.done = done_reg;
    assign cos_q    = cos_reg;
    assign sin_q    = sin_reg;

endmodule

// ----- rtl/cloop_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cloop_div: unsigned restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module cloop_div
    import cloop_pkg::*;
#(
    parameter int NW = DIV_NUM_W,
    parameter int DW = DIV_DEN_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output unit_sts_t     sts,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg, den_reg;
    logic [NW-1:0] quo_reg;

    logic [DW:0]   shifted, diff;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule
